FILE: sv/msw_pkg.sv
`timescale 1ns / 1ps

package msw_pkg;

    localparam int MAX_TAPS     = 10;
    localparam int TAPS_DEFAULT = 10;

    localparam int DATA_W   = 16;
    localparam int WEIGHT_W = 5;
    // Largest single term is 65535 * 30; largest sum is 65535 * 100.
    localparam int TERM_W   = DATA_W + WEIGHT_W;
    localparam int SUM_W    = 23;

    // Weights in hundredths, newest tap first.
    localparam logic [WEIGHT_W-1:0] TAP_WEIGHT [MAX_TAPS] = '{
        5'd30, 5'd25, 5'd15, 5'd10, 5'd5, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1
    };

    // Division by 100 as a multiplication by ceil(2^30 / 100). The error term
    // is small enough that the quotient is exact for every sum below 2^23.
    localparam int              RECIP_W     = 24;
    localparam int              RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int              PROD_W      = SUM_W + RECIP_W;

    // Registered stages from an input transfer to the output register.
    localparam int PIPE_DEPTH = 5;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPIKE_THRESHOLD = 2'd0,
        REG_CLAMP_LOW       = 2'd1,
        REG_CLAMP_HIGH      = 2'd2
    } cfg_reg_t;

    localparam logic [DATA_W-1:0] SPIKE_THRESHOLD_RESET = 16'd10;
    localparam logic [DATA_W-1:0] CLAMP_LOW_RESET       = 16'd2;
    localparam logic [DATA_W-1:0] CLAMP_HIGH_RESET      = 16'd400;

    // What one cell hands to the next one along the line.
    typedef struct packed {
        logic [DATA_W-1:0] raw;
        logic [DATA_W-1:0] clean;
        logic              alive;
    } cell_link_t;

endpackage

FILE: sv/msw_cell.sv
`timescale 1ns / 1ps

// One tap of both delay lines together with its weighted term.
module msw_cell #(
    parameter logic [msw_pkg::WEIGHT_W-1:0] WEIGHT = msw_pkg::TAP_WEIGHT[0],
    parameter bit                           FIRST  = 1'b0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  msw_pkg::cell_link_t         link_in,
    output msw_pkg::cell_link_t         link_out,
    output logic [msw_pkg::TERM_W-1:0]  term
);

    logic [msw_pkg::DATA_W-1:0] raw_reg;
    logic [msw_pkg::DATA_W-1:0] clean_reg;
    logic [msw_pkg::TERM_W-1:0] term_reg;
    logic [msw_pkg::TERM_W-1:0] term_next;
    logic                       enable;

    // The incoming values are the ones this tap holds after the shift. The
    // newest tap always counts; later ones only while no raw zero came before.
    assign enable = link_in.alive & (FIRST | (link_in.raw != '0));

    assign term_next = enable
        ? msw_pkg::TERM_W'(link_in.clean) * msw_pkg::TERM_W'(WEIGHT)
        : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg   <= '0;
            clean_reg <= '0;
        end
        else if (load)
        begin
            raw_reg   <= link_in.raw;
            clean_reg <= link_in.clean;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_reg <= term_next;
        end
    end

    assign link_out.raw   = raw_reg;
    assign link_out.clean = clean_reg;
    assign link_out.alive = enable;
    assign term           = term_reg;

endmodule

FILE: sv/msw_despike.sv
`timescale 1ns / 1ps

// Median of the newest three raw values and replacement of outliers.
module msw_despike (
    input  logic [msw_pkg::DATA_W-1:0] newest,
    input  logic [msw_pkg::DATA_W-1:0] prev1,
    input  logic [msw_pkg::DATA_W-1:0] prev2,
    input  logic [msw_pkg::DATA_W-1:0] threshold,
    output logic [msw_pkg::DATA_W-1:0] clean,
    output logic                       replaced
);

    logic [msw_pkg::DATA_W-1:0] median;
    logic [msw_pkg::DATA_W-1:0] spread;

    always_comb
    begin
        if ((newest <= prev1 && prev1 <= prev2) || (prev2 <= prev1 && prev1 <= newest))
        begin
            median = prev1;
        end
        else if ((prev1 <= newest && newest <= prev2) || (prev2 <= newest && newest <= prev1))
        begin
            median = newest;
        end
        else
        begin
            median = prev2;
        end

        spread = (newest > median) ? (newest - median) : (median - newest);

        // While the third-newest raw value is zero there is no median.
        if ((prev2 != '0) && (spread > threshold))
        begin
            clean    = median;
            replaced = 1'b1;
        end
        else
        begin
            clean    = newest;
            replaced = 1'b0;
        end
    end

endmodule

FILE: sv/median_spike_weighted_average_filter_unit.sv
`timescale 1ns / 1ps

// Distance smoothing filter. Each reading transferred on the s_ channel is
// checked against the median of the newest three raw readings and replaced by
// that median when it lies further away than spike_threshold (only while the
// third-newest raw reading is nonzero); the result then enters a line of TAPS
// cells whose weighted sum, in hundredths, is divided by 100 and clamped to
// [clamp_low, clamp_high]. A raw reading of zero means no data and stops the
// sum at that tap, except at the newest tap. The block takes one reading per
// clock cycle unless every stage is full behind a stalled output, and gives
// one result per reading, in order. The result reaches m_tdata through five
// register stages: cell terms, two partial sums, the full sum, the reciprocal
// multiply for the division and the clamp into the output register. Every
// stage only waits when the stage after it is full, so a result held on the
// output does not stop readings from entering until all five are occupied.
// cfg_ready is always high; write the registers only while no reading is in
// flight.
module median_spike_weighted_average_filter_unit #(
    parameter int TAPS = msw_pkg::TAPS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream. s_tdata: [15:0] reading.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [msw_pkg::DATA_W-1:0]       s_tdata,
    // Output stream. m_tdata: [15:0] distance. m_tuser: [0] spike_replaced.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [msw_pkg::DATA_W-1:0]       m_tdata,
    output logic [0:0]                       m_tuser,
    // Register writes: 0 spike_threshold, 1 clamp_low, 2 clamp_high.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [msw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [msw_pkg::DATA_W-1:0]       cfg_data
);

    localparam int HALF = (TAPS + 1) / 2;

    // Configuration registers.
    logic [msw_pkg::DATA_W-1:0] threshold_reg;
    logic [msw_pkg::DATA_W-1:0] clamp_low_reg;
    logic [msw_pkg::DATA_W-1:0] clamp_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= msw_pkg::SPIKE_THRESHOLD_RESET;
            clamp_low_reg  <= msw_pkg::CLAMP_LOW_RESET;
            clamp_high_reg <= msw_pkg::CLAMP_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (msw_pkg::cfg_reg_t'(cfg_index))
                msw_pkg::REG_SPIKE_THRESHOLD: threshold_reg  <= cfg_data;
                msw_pkg::REG_CLAMP_LOW:       clamp_low_reg  <= cfg_data;
                msw_pkg::REG_CLAMP_HIGH:      clamp_high_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Pipeline occupancy. A stage moves on when the next one is empty or moving.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ready2, ready3, ready4, ready5;
    logic s_accept;

    assign ready5   = !v5_reg || m_tready;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign s_tready = !v1_reg || ready2;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                v1_reg <= s_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Despike the incoming reading against the two raw values already held.
    msw_pkg::cell_link_t        link [TAPS+1];
    logic [msw_pkg::TERM_W-1:0] term [TAPS];
    logic [msw_pkg::DATA_W-1:0] despiked;
    logic                       replaced;

    msw_despike u_despike (
        .newest    (s_tdata),
        .prev1     (link[1].raw),
        .prev2     (link[2].raw),
        .threshold (threshold_reg),
        .clean     (despiked),
        .replaced  (replaced)
    );

    assign link[0].raw   = s_tdata;
    assign link[0].clean = despiked;
    assign link[0].alive = 1'b1;

    // The row of cells: both delay lines shift by one tap on every transfer,
    // and each cell registers its weighted term for that same reading.
    genvar gi;
    generate
        for (gi = 0; gi < TAPS; gi++)
        begin : g_cell
            msw_cell #(
                .WEIGHT (msw_pkg::TAP_WEIGHT[gi]),
                .FIRST  (gi == 0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (s_accept),
                .link_in  (link[gi]),
                .link_out (link[gi+1]),
                .term     (term[gi])
            );
        end
    endgenerate

    logic rep1_reg, rep2_reg, rep3_reg, rep4_reg, rep5_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            rep1_reg <= replaced;
        end
    end

    // Two partial sums, then the full sum.
    logic [msw_pkg::SUM_W-1:0] lo_next, hi_next;
    logic [msw_pkg::SUM_W-1:0] lo_reg, hi_reg;
    logic [msw_pkg::SUM_W-1:0] sum_reg;

    always_comb
    begin
        lo_next = '0;
        hi_next = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            if (i < HALF)
            begin
                lo_next = lo_next + msw_pkg::SUM_W'(term[i]);
            end
            else
            begin
                hi_next = hi_next + msw_pkg::SUM_W'(term[i]);
            end
        end
    end

    // The division by 100 is a multiplication by a scaled reciprocal; the
    // quotient is the part of the product above the scaling shift.
    logic [msw_pkg::PROD_W-1:0] prod;
    logic [msw_pkg::DATA_W-1:0] quot_reg;
    logic [msw_pkg::DATA_W-1:0] clamped;
    logic [msw_pkg::DATA_W-1:0] dist_reg;

    assign prod = msw_pkg::PROD_W'(sum_reg) * msw_pkg::PROD_W'(msw_pkg::RECIP_100);

    // The lower limit is tested first, so inverted limits favour clamp_low
    // only for values below it.
    always_comb
    begin
        if (quot_reg < clamp_low_reg)
        begin
            clamped = clamp_low_reg;
        end
        else if (quot_reg > clamp_high_reg)
        begin
            clamped = clamp_high_reg;
        end
        else
        begin
            clamped = quot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            rep2_reg <= rep1_reg;
        end
        if (ready3)
        begin
            sum_reg  <= lo_reg + hi_reg;
            rep3_reg <= rep2_reg;
        end
        if (ready4)
        begin
            quot_reg <= prod[msw_pkg::RECIP_SHIFT +: msw_pkg::DATA_W];
            rep4_reg <= rep3_reg;
        end
        if (ready5)
        begin
            dist_reg <= clamped;
            rep5_reg <= rep4_reg;
        end
    end

    assign m_tvalid   = v5_reg;
    assign m_tdata    = dist_reg;
    assign m_tuser[0] = rep5_reg;

endmodule

FILE: sv/msw_checker.sv
`timescale 1ns / 1ps

// Port-level checks: result hold under back-pressure and item bookkeeping.
module msw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [msw_pkg::DATA_W-1:0]      m_tdata,
    input logic [0:0]                      m_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
        begin
            pending_next = pending_reg + 4'd1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No more items in flight than register stages, and none invented.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg <= 4'(msw_pkg::PIPE_DEPTH)) && (!m_tvalid || pending_reg != '0))
        else $error("item count out of range");

    // Input is refused only when every stage holds an item.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> pending_reg == 4'(msw_pkg::PIPE_DEPTH))
        else $error("input stalled with room in the pipeline");

    // A result appears once an input to an empty block has passed every register stage.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && pending_reg == '0 |-> ##5 m_tvalid)
        else $error("result missing after pipeline latency");

    // The register port never stalls.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind median_spike_weighted_average_filter_unit msw_checker u_msw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

FILE: dv/distance_filter_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the distance filter, keeps its own copy of
// the delay lines and limits, and compares every output transfer with the
// oldest predicted result.
module distance_filter_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [msw_pkg::DATA_W-1:0]      s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [msw_pkg::DATA_W-1:0]      m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [msw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [msw_pkg::DATA_W-1:0]      cfg_data,
    input  logic                            drain_done,
    output int                              error_count,
    output int                              outstanding_results
);

    localparam int TAPS = msw_pkg::TAPS_DEFAULT;

    typedef struct packed {
        logic [msw_pkg::DATA_W-1:0] distance;
        logic                       spike_replaced;
    } filter_result_t;

    logic [msw_pkg::DATA_W-1:0] raw_hist [TAPS];
    logic [msw_pkg::DATA_W-1:0] clean_hist [TAPS];
    logic [msw_pkg::DATA_W-1:0] spike_limit;
    logic [msw_pkg::DATA_W-1:0] floor_limit;
    logic [msw_pkg::DATA_W-1:0] ceiling_limit;
    filter_result_t             pending_results [$];
    filter_result_t             predicted;
    filter_result_t             oldest;
    bit                         leftover_checked;

    function automatic int unsigned tap_weight(input int tap);
        case (tap)
            0:       return 30;
            1:       return 25;
            2:       return 15;
            3:       return 10;
            4:       return 5;
            5:       return 5;
            6:       return 4;
            7:       return 3;
            8:       return 2;
            default: return 1;
        endcase
    endfunction

    function automatic logic [msw_pkg::DATA_W-1:0] median_of_three(
        input logic [msw_pkg::DATA_W-1:0] a,
        input logic [msw_pkg::DATA_W-1:0] b,
        input logic [msw_pkg::DATA_W-1:0] c
    );
        logic [msw_pkg::DATA_W-1:0] lower;
        logic [msw_pkg::DATA_W-1:0] upper;
        lower = (a < b) ? a : b;
        upper = (a < b) ? b : a;
        if (c <= lower)
            return lower;
        if (c >= upper)
            return upper;
        return c;
    endfunction

    task report_mismatch(input string what);
        $display("%0t ns: mismatch, %s", $realtime, what);
        error_count++;
    endtask

    // Shifts one reading through both lines and forms the expected result.
    task advance_filter(input logic [msw_pkg::DATA_W-1:0] reading,
                        output filter_result_t result);
        logic [msw_pkg::DATA_W-1:0] clean;
        logic [msw_pkg::DATA_W-1:0] centre;
        logic [msw_pkg::DATA_W-1:0] spread;
        int unsigned                acc;
        int unsigned                quotient;
        bit                         live;
        for (int i = TAPS - 1; i > 0; i--)
            raw_hist[i] = raw_hist[i-1];
        raw_hist[0] = reading;
        clean = reading;
        result.spike_replaced = 1'b0;
        if (raw_hist[2] != '0)
        begin
            centre = median_of_three(raw_hist[0], raw_hist[1], raw_hist[2]);
            spread = (reading > centre) ? reading - centre : centre - reading;
            if (spread > spike_limit)
            begin
                clean = centre;
                result.spike_replaced = 1'b1;
            end
        end
        for (int i = TAPS - 1; i > 0; i--)
            clean_hist[i] = clean_hist[i-1];
        clean_hist[0] = clean;
        acc  = 0;
        live = 1;
        for (int i = 0; i < TAPS; i++)
        begin
            if (i > 0 && raw_hist[i] == '0)
                live = 0;
            if (live)
                acc += int'(clean_hist[i]) * tap_weight(i);
        end
        quotient = acc / 100;
        if (quotient < floor_limit)
            result.distance = floor_limit;
        else if (quotient > ceiling_limit)
            result.distance = ceiling_limit;
        else
            result.distance = quotient[msw_pkg::DATA_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                raw_hist[i]   = '0;
                clean_hist[i] = '0;
            end
            spike_limit   = msw_pkg::SPIKE_THRESHOLD_RESET;
            floor_limit   = msw_pkg::CLAMP_LOW_RESET;
            ceiling_limit = msw_pkg::CLAMP_HIGH_RESET;
            pending_results.delete();
            outstanding_results = 0;
            error_count         = 0;
            leftover_checked    = 0;
        end
        else
        begin
            // Pop before push, so that a result can never be matched with
            // the reading accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result %0d/%0b with no reading waiting",
                                              m_tdata, m_tuser[0]));
                else
                begin
                    oldest = pending_results.pop_front();
                    if (m_tdata !== oldest.distance)
                        report_mismatch($sformatf("distance %0d, expected %0d",
                                                  m_tdata, oldest.distance));
                    if (m_tuser[0] !== oldest.spike_replaced)
                        report_mismatch($sformatf("spike_replaced %0b, expected %0b",
                                                  m_tuser[0], oldest.spike_replaced));
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_filter(s_tdata, predicted);
                pending_results.push_back(predicted);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    msw_pkg::REG_SPIKE_THRESHOLD: spike_limit   = cfg_data;
                    msw_pkg::REG_CLAMP_LOW:       floor_limit   = cfg_data;
                    msw_pkg::REG_CLAMP_HIGH:      ceiling_limit = cfg_data;
                    default:                      ;
                endcase
            end
            outstanding_results = pending_results.size();
            if (drain_done && !leftover_checked)
            begin
                leftover_checked = 1;
                if (pending_results.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              pending_results.size()));
            end
        end
    end

endmodule

FILE: dv/tb_median_spike_weighted_average_filter_unit.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the distance smoothing filter. The checker beside
// the block does all the prediction and comparison; this module only drives
// readings and register writes, throttles the output side and reports the
// outcome.
module tb_median_spike_weighted_average_filter_unit;

    localparam int RESET_CYCLES    = 11;
    localparam int DIRECTED_COUNT  = 25;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 235;
    // Margin for the path from input to output of the block.
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_IDLE        = 8;
    localparam int MODE_STRETCH    = 40;

    // Index 3 is not mapped to any register, so writes to it must be ignored.
    localparam logic [msw_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [msw_pkg::DATA_W-1:0]      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [msw_pkg::DATA_W-1:0]      m_tdata;
    logic [0:0]                      m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [msw_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [msw_pkg::DATA_W-1:0]      cfg_data;
    logic                            drain_done;
    int                              error_count;
    int                              outstanding_results;

    // When set, the corresponding side runs without any idle cycles.
    bit tx_calm;
    bit rx_calm;
    // Current distance level around which plausible readings are drawn.
    int level;

    median_spike_weighted_average_filter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    distance_filter_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .drain_done          (drain_done),
        .error_count         (error_count),
        .outstanding_results (outstanding_results)
    );

    always #6 clk = ~clk;

    function automatic int idle_cycles(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // The directed readings: the first few arrive while the third-newest raw
    // value is still zero, so no median can be formed. Later ones provide an
    // obvious spike, a zero at the newest tap, a run of full-scale values, small
    // values and alternating bit patterns.
    function automatic logic [msw_pkg::DATA_W-1:0] directed_reading(input int n);
        case (n)
            0:       return 16'd0;
            1:       return 16'd120;
            2:       return 16'd0;
            3:       return 16'd120;
            4:       return 16'd121;
            5:       return 16'd122;
            6:       return 16'd400;
            7:       return 16'd123;
            8:       return 16'hFFFF;
            9:       return 16'hFFFF;
            10:      return 16'hFFFF;
            11:      return 16'hFFFF;
            12:      return 16'd1;
            13:      return 16'd2;
            14:      return 16'd3;
            15:      return 16'h5555;
            16:      return 16'hAAAA;
            17:      return 16'h8000;
            18:      return 16'h7FFF;
            19:      return 16'd0;
            20:      return 16'd0;
            21:      return 16'd200;
            22:      return 16'd200;
            23:      return 16'd210;
            default: return 16'd211;
        endcase
    endfunction

    // Mostly plausible sensor traffic around a slowly moving level, with
    // spikes in both directions, dropouts, full-range noise and the odd jump
    // of the level itself.
    function automatic logic [msw_pkg::DATA_W-1:0] next_reading();
        int kind;
        int value;
        kind = $urandom_range(0, 99);
        if (kind < 55)
            value = level + int'($urandom_range(0, 24)) - 12;
        else if (kind < 66)
            value = level + int'($urandom_range(30, 4000));
        else if (kind < 72)
            value = level - int'($urandom_range(30, 2000));
        else if (kind < 80)
            value = 0;
        else if (kind < 87)
            value = int'($urandom_range(0, 65535));
        else if (kind < 90)
            value = 65535;
        else
        begin
            if (kind >= 98)
                level = int'($urandom_range(1, 65535));
            else
                level = int'($urandom_range(1, 1200));
            value = level;
        end
        if (value < 0)
            value = 0;
        if (value > 65535)
            value = 65535;
        return value[msw_pkg::DATA_W-1:0];
    endfunction

    // One input transfer. The valid line stays high between back-to-back
    // readings; it is only lowered when an idle gap has been drawn.
    task send_reading(input logic [msw_pkg::DATA_W-1:0] value);
        int gap;
        gap = idle_cycles(tx_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task write_reg(input logic [msw_pkg::CFG_INDEX_W-1:0] index,
                   input logic [msw_pkg::DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Waits until every predicted result has been transferred, then gives
    // the pipeline a few more cycles to empty completely.
    task settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (outstanding_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Each phase runs with its own threshold and limits. The list covers
    // a zero threshold, a threshold that never fires, both extremes of the
    // limits and two cases of inverted limits; the last phases are random.
    task program_limits(input int phase);
        logic [msw_pkg::DATA_W-1:0] threshold;
        logic [msw_pkg::DATA_W-1:0] floor_value;
        logic [msw_pkg::DATA_W-1:0] ceiling_value;
        case (phase)
            0:
            begin
                threshold = 16'd10; floor_value = 16'd2; ceiling_value = 16'd400;
            end
            1:
            begin
                threshold = 16'd0; floor_value = 16'd0; ceiling_value = 16'hFFFF;
            end
            2:
            begin
                threshold = 16'hFFFF; floor_value = 16'd0; ceiling_value = 16'hFFFF;
            end
            3:
            begin
                threshold = 16'd500; floor_value = 16'd1000; ceiling_value = 16'd200;
            end
            4:
            begin
                threshold = 16'hFFFF; floor_value = 16'hFFFF; ceiling_value = 16'hFFFF;
            end
            5:
            begin
                threshold = 16'd0; floor_value = 16'hFFFF; ceiling_value = 16'd0;
            end
            default:
            begin
                threshold     = 16'($urandom_range(0, 80));
                floor_value   = 16'($urandom_range(0, 60));
                ceiling_value = 16'($urandom_range(100, 3000));
            end
        endcase
        write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
        write_reg(msw_pkg::REG_SPIKE_THRESHOLD, threshold);
        write_reg(msw_pkg::REG_CLAMP_LOW, floor_value);
        write_reg(msw_pkg::REG_CLAMP_HIGH, ceiling_value);
    endtask

    // Output side: for every result a number of cycles with tready low is
    // drawn, after which tready stays high until the transfer happens.
    initial
    begin : output_throttle
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = idle_cycles(rx_calm);
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin : stimulus
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        drain_done = 1'b0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        level      = 150;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed readings run with the reset values of the registers.
        for (int n = 0; n < DIRECTED_COUNT; n++)
            send_reading(directed_reading(n));

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            program_limits(phase);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Now and then a stretch in which one or both sides never idle.
                if (n % MODE_STRETCH == 0)
                begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                send_reading(next_reading());
            end
        end

        settle();
        drain_done = 1'b1;
        @(negedge clk);
        @(negedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial
    begin : watchdog
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
